FILE: design/assert_macros.svh
// Assertion macros used by the checker file of the semaphore block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is low
`define CSEM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define CSEM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`CSEM_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: design/csem_pkg.sv
// Package for the counting semaphore: sizes, operation codes and the
// structs passed between the top level and the semaphore core. No dependencies.
package csem_pkg;

	// Queue and task id sizing
	localparam int QUEUE_DEPTH  = 16;
	localparam int TASK_ID_BITS = 8;
	localparam int PTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int TOTAL_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W        = TOTAL_W + 1;

	// Port widths fixed by the interface
	localparam int MODE_W      = 2;
	localparam int ID_PORT_W   = 8;
	localparam int COUNT_W     = 16;
	localparam int INIT_W      = 15;
	localparam int WAIT_PORT_W = 5;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
	localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

	// Register index within the configuration space
	localparam logic REG_INITIAL_COUNT = 1'b0;

	typedef enum logic [MODE_W-1:0] {
		MODE_WAIT    = 2'd0,
		MODE_TRYWAIT = 2'd1,
		MODE_POST    = 2'd2
	} mode_t;

	// Accepted request held in the input stage
	typedef struct packed {
		logic                    valid;
		mode_t                   mode;
		logic [TASK_ID_BITS-1:0] caller;
	} csem_op_t;

	// Configuration load toward the core
	typedef struct packed {
		logic              load;
		logic [INIT_W-1:0] value;
	} csem_load_t;

	// Result of one request
	typedef struct packed {
		logic                       granted;
		logic                       caller_blocks;
		logic                       woken_valid;
		logic [TASK_ID_BITS-1:0]    woken_task;
		logic                       queue_full_error;
		logic signed [COUNT_W-1:0]  count_after;
		logic [TOTAL_W-1:0]         waiters_after;
	} csem_result_t;

endpackage

FILE: design/csem_core.sv
// Semaphore core: count, wait ring, head pointer and waiter total, and the
// combinational update for one request. Depends on csem_pkg.
module csem_core import csem_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  csem_load_t   cfg,
	input  csem_op_t     op,
	output csem_result_t res
);

	logic signed [COUNT_W-1:0] count_q, count_d, count_dec;
	logic [PTR_W-1:0]          head_q, head_d, tail;
	logic [TOTAL_W-1:0]        total_q, total_d;
	logic [SUM_W-1:0]          tail_sum;
	logic [TASK_ID_BITS-1:0]   ring_q [QUEUE_DEPTH];
	logic                      ring_we;

	// Saturating decrement and tail slot of the ring
	assign count_dec = (count_q == COUNT_MIN) ? count_q : count_q - 16'sd1;
	assign tail_sum  = SUM_W'(head_q) + SUM_W'(total_q);
	assign tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH))
		? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);

	// Decide the outcome of the request in the input stage
	always_comb begin
		res     = '0;
		count_d = count_q;
		head_d  = head_q;
		total_d = total_q;
		ring_we = 1'b0;
		if (op.valid) begin
			case (op.mode)
				MODE_WAIT: begin
					if (count_dec[COUNT_W-1]) begin
						if (total_q >= TOTAL_W'(QUEUE_DEPTH)) begin
							res.queue_full_error = 1'b1;
						end else begin
							ring_we           = 1'b1;
							total_d           = total_q + 1'b1;
							count_d           = count_dec;
							res.caller_blocks = 1'b1;
						end
					end else begin
						count_d     = count_dec;
						res.granted = 1'b1;
					end
				end
				MODE_TRYWAIT: begin
					if (count_q > 16'sd0) begin
						count_d     = count_q - 16'sd1;
						res.granted = 1'b1;
					end
				end
				MODE_POST: begin
					res.granted = 1'b1;
					if (count_q != COUNT_MAX) begin
						count_d = count_q + 16'sd1;
					end
					// Release the oldest waiter
					if (total_q != '0) begin
						res.woken_valid = 1'b1;
						res.woken_task  = ring_q[head_q];
						head_d = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
						total_d = total_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		res.count_after   = count_d;
		res.waiters_after = total_d;
	end

	// Advance the semaphore state; a configuration load restarts it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
			total_q <= '0;
		end else if (cfg.load) begin
			count_q <= COUNT_W'(cfg.value);
			head_q  <= '0;
			total_q <= '0;
		end else begin
			count_q <= count_d;
			head_q  <= head_d;
			total_q <= total_d;
		end
	end

	// Append the blocked caller at the tail
	always_ff @(posedge clk) begin
		if (ring_we && !cfg.load) begin
			ring_q[tail] <= op.caller;
		end
	end

endmodule

FILE: design/counting_semaphore_with_wait_queue.sv
// Counting semaphore with a FIFO wait queue of task ids.
// Flow: start and the request are registered in the input stage; the result and done in the output stage.
// Throughput: one request per cycle; busy stays low.
// Reset: count 0, queue empty, initial_count register 0; no clearing pass.
// Writing initial_count reloads the count and empties the queue.
// Depends on csem_pkg and csem_core.
module counting_semaphore_with_wait_queue import csem_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// APB configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready,
	// Request side
	input  logic                      start,
	output logic                      busy,
	input  logic [MODE_W-1:0]         mode,
	input  logic [ID_PORT_W-1:0]      caller_id,
	// Result side
	output logic                      done,
	output logic                      granted,
	output logic                      caller_blocks,
	output logic                      woken_valid,
	output logic [ID_PORT_W-1:0]      woken_task,
	output logic                      queue_full_error,
	output logic signed [COUNT_W-1:0] count_after,
	output logic [WAIT_PORT_W-1:0]    waiters_after
);

	logic              reg_index;
	logic              cfg_write;
	logic [INIT_W-1:0] init_q;
	csem_load_t        cfg;
	csem_op_t          op_s1;
	csem_result_t      res_comb, res_s2;
	logic              done_s2;

	// Decode the APB write
	assign pready    = 1'b1;
	assign reg_index = paddr[ADDR_W-1];
	assign cfg_write = psel && penable && pwrite && pready && (reg_index == REG_INITIAL_COUNT);
	assign cfg       = '{load: cfg_write, value: pwdata[INIT_W-1:0]};
	assign prdata    = (reg_index == REG_INITIAL_COUNT) ? DATA_W'(init_q) : '0;

	// Hold the initial count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
		end else if (cfg_write) begin
			init_q <= pwdata[INIT_W-1:0];
		end
	end

	// Capture the request
	assign busy = 1'b0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1.valid  <= start && !busy;
			op_s1.mode   <= mode_t'(mode);
			op_s1.caller <= caller_id[TASK_ID_BITS-1:0];
		end
	end

	csem_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.op     (op_s1),
		.res    (res_comb)
	);

	// Register the result and its strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= op_s1.valid;
		end
	end
	always_ff @(posedge clk) begin
		res_s2 <= res_comb;
	end

	assign done             = done_s2;
	assign granted          = res_s2.granted;
	assign caller_blocks    = res_s2.caller_blocks;
	assign woken_valid      = res_s2.woken_valid;
	assign woken_task       = ID_PORT_W'(res_s2.woken_task);
	assign queue_full_error = res_s2.queue_full_error;
	assign count_after      = res_s2.count_after;
	assign waiters_after    = WAIT_PORT_W'(res_s2.waiters_after);

endmodule

FILE: design/csem_checker.sv
// Port-level checks for the counting semaphore, bound to its top level.
// Depends on csem_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csem_checker import csem_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic                      granted,
	input logic                      caller_blocks,
	input logic                      woken_valid,
	input logic [ID_PORT_W-1:0]      woken_task,
	input logic                      queue_full_error,
	input logic signed [COUNT_W-1:0] count_after
);

	// Every accepted request gets its result once it has passed the input and output registers
	`CSEM_ASSERT(a_result_follows, clk, arst_n, start && !busy |-> ##2 done, "request lost")

	// No result without a matching accepted request ahead of it
	`CSEM_ASSERT(a_no_spurious, clk, arst_n, !(start && !busy) |-> ##2 !done, "spurious result")

	// A refused wait raises no other outcome flag
	`CSEM_ASSERT_NEVER(a_full_clean, clk, arst_n,
		done && queue_full_error && (granted || caller_blocks || woken_valid),
		"full error with other flags")

	// A queued caller leaves the count negative
	`CSEM_ASSERT(a_block_negative, clk, arst_n, done && caller_blocks |-> count_after[COUNT_W-1],
		"blocked caller with non-negative count")

	// Woken id is clear when no task is released
	`CSEM_ASSERT(a_woken_zero, clk, arst_n, done && !woken_valid |-> woken_task == '0,
		"woken id without release")

endmodule

bind counting_semaphore_with_wait_queue csem_checker u_csem_checker (.*);

FILE: sim/counting_semaphore_with_wait_queue_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the counting semaphore with its FIFO wait queue.
// Depends on csem_pkg and the counting_semaphore_with_wait_queue top level.
module counting_semaphore_with_wait_queue_test;
	import csem_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int LATENCY     = 2;
	localparam int CYCLE_LIMIT = 50000;
	localparam int PHASE_ITEMS = 62;
	localparam int PHASES      = 8;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [ADDR_W-1:0] ADDR_INITIAL_COUNT = ADDR_W'(4 * REG_INITIAL_COUNT);

	// Tracks the semaphore and holds the outcomes still owed by the block
	class semaphore_ledger;
		int count;
		logic [TASK_ID_BITS-1:0] ring [QUEUE_DEPTH];
		int head;
		int total;
		csem_result_t outcome_q [$];
		int fails;
		int requests;
		int settings;
		int blocked;
		int woken;
		int refused;

		function new();
			for (int i = 0; i < QUEUE_DEPTH; i++) ring[i] = '0;
			fails = 0;
			requests = 0;
			settings = 0;
			blocked = 0;
			woken = 0;
			refused = 0;
			reload('0);
		endfunction

		// Load a new count and empty the queue
		function void reload(logic [INIT_W-1:0] value);
			count = int'(value);
			head = 0;
			total = 0;
			settings++;
		endfunction

		function string show(csem_result_t r);
			return $sformatf("granted=%b blocks=%b woken=%b/%h full=%b count=%0d waiters=%0d",
				r.granted, r.caller_blocks, r.woken_valid, r.woken_task,
				r.queue_full_error, r.count_after, r.waiters_after);
		endfunction

		// Apply one accepted request and queue the outcome it must produce
		function void log_request(logic [MODE_W-1:0] m, logic [ID_PORT_W-1:0] id);
			csem_result_t r;
			int next;
			int tail;
			r = '0;
			requests++;
			case (m)
				MODE_WAIT: begin
					next = (count > COUNT_MIN) ? count - 1 : int'(COUNT_MIN);
					if (next < 0) begin
						if (total >= QUEUE_DEPTH) begin
							r.queue_full_error = 1'b1;
							refused++;
						end else begin
							tail = (head + total) % QUEUE_DEPTH;
							ring[tail] = id[TASK_ID_BITS-1:0];
							total++;
							count = next;
							r.caller_blocks = 1'b1;
							blocked++;
						end
					end else begin
						count = next;
						r.granted = 1'b1;
					end
				end
				MODE_TRYWAIT: begin
					if (count > 0) begin
						count--;
						r.granted = 1'b1;
					end
				end
				MODE_POST: begin
					r.granted = 1'b1;
					if (count < COUNT_MAX) count++;
					if (total > 0) begin
						r.woken_valid = 1'b1;
						r.woken_task = ring[head];
						head = (head + 1) % QUEUE_DEPTH;
						total--;
						woken++;
					end
				end
				default: ;
			endcase
			r.count_after = COUNT_W'(count);
			r.waiters_after = TOTAL_W'(total);
			outcome_q.push_back(r);
		endfunction

		// Compare a strobed result with the oldest owed outcome
		function void match_outcome(csem_result_t got);
			csem_result_t want;
			if (outcome_q.size() == 0) begin
				fails++;
				$display("%0t: result with no request pending: %s", $time, show(got));
				return;
			end
			want = outcome_q.pop_front();
			if (got !== want) begin
				fails++;
				$display("%0t: result mismatch\n  expected %s\n  actual   %s",
					$time, show(want), show(got));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic start;
	logic busy;
	logic [MODE_W-1:0] mode;
	logic [ID_PORT_W-1:0] caller_id;
	logic done;
	logic granted;
	logic caller_blocks;
	logic woken_valid;
	logic [ID_PORT_W-1:0] woken_task;
	logic queue_full_error;
	logic signed [COUNT_W-1:0] count_after;
	logic [WAIT_PORT_W-1:0] waiters_after;

	csem_result_t observed;
	semaphore_ledger ledger;
	int cycle_count = 0;
	bit calm_stretch = 1'b0;

	counting_semaphore_with_wait_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.mode(mode),
		.caller_id(caller_id),
		.done(done),
		.granted(granted),
		.caller_blocks(caller_blocks),
		.woken_valid(woken_valid),
		.woken_task(woken_task),
		.queue_full_error(queue_full_error),
		.count_after(count_after),
		.waiters_after(waiters_after)
	);

	assign observed = {granted, caller_blocks, woken_valid, woken_task,
		queue_full_error, count_after, waiters_after};

	always #CLK_HALF clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", CYCLE_LIMIT);
			$display("FAIL counting_semaphore_with_wait_queue");
			$finish;
		end
	end

	// Watch results, accepted requests and register writes
	always @(posedge clk) begin
		if (arst_n && ledger != null) begin
			if (done === 1'b1) ledger.match_outcome(observed);
			if (start && !busy) ledger.log_request(mode, caller_id);
			if (psel && penable && pwrite && pready && paddr == ADDR_INITIAL_COUNT)
				ledger.reload(pwdata[INIT_W-1:0]);
		end
	end

	// Issue one request, with an optional idle gap ahead of it
	task automatic send_request(input logic [MODE_W-1:0] m, input logic [ID_PORT_W-1:0] id);
		if (!calm_stretch) begin
			while ($urandom_range(99) < 31) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		mode <= m;
		caller_id <= id;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Wait until every owed outcome has come back, then let the block settle
	task automatic drain;
		@(negedge clk);
		while (ledger.outcome_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Write the initial count register through a setup and an access cycle
	task automatic write_initial_count(input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_INITIAL_COUNT;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Pick a mode for random traffic, with a little unused-mode noise
	function automatic logic [MODE_W-1:0] pick_mode(logic [MODE_W-1:0] usual);
		if ($urandom_range(19) == 0) return MODE_UNUSED;
		return usual;
	endfunction

	initial begin
		int burst;
		int kind;
		int issued;
		logic [INIT_W-1:0] init_value;
		logic [MODE_W-1:0] m;

		ledger = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		mode <= MODE_WAIT;
		caller_id <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unused mode, try-wait on zero, post to an empty queue,
		// fill the queue, refuse a wait on a full queue, wake the oldest
		send_request(MODE_UNUSED, 8'h5A);
		send_request(MODE_TRYWAIT, 8'h01);
		send_request(MODE_POST, 8'h02);
		send_request(MODE_TRYWAIT, 8'h03);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_request(MODE_WAIT, (i == 1) ? 8'hFF : ID_PORT_W'(i * 17));
		send_request(MODE_WAIT, 8'hAA);
		send_request(MODE_POST, 8'h00);
		start <= 1'b0;
		drain();

		// Directed: saturate the count at its top
		write_initial_count(32'hFFFF_FFFF);
		send_request(MODE_POST, 8'hC3);
		send_request(MODE_WAIT, 8'h3C);
		send_request(MODE_TRYWAIT, 8'h7E);
		start <= 1'b0;
		drain();

		// Random phases, each from a fresh count
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: init_value = '0;
				1: init_value = 15'h7FFF;
				2: init_value = 15'd1;
				5: init_value = INIT_W'($urandom_range(32767));
				default: init_value = INIT_W'($urandom_range(6));
			endcase
			write_initial_count({DATA_W'($urandom) << INIT_W} | DATA_W'(init_value));
			@(posedge clk);
			calm_stretch = (p == 3);
			issued = 0;
			while (issued < PHASE_ITEMS) begin
				kind = $urandom_range(9);
				burst = $urandom_range(18, 1);
				for (int b = 0; b < burst && issued < PHASE_ITEMS; b++) begin
					case (kind)
						0, 1, 2, 3: m = pick_mode(MODE_WAIT);
						4, 5, 6: m = pick_mode(MODE_POST);
						9: m = pick_mode(MODE_TRYWAIT);
						default: m = MODE_W'($urandom_range(3));
					endcase
					send_request(m, ID_PORT_W'($urandom_range(255)));
					issued++;
				end
			end
			start <= 1'b0;
			calm_stretch = 1'b0;
			drain();
		end

		if (ledger.outcome_q.size() != 0) begin
			ledger.fails++;
			$display("%0t: %0d results never arrived", $time, ledger.outcome_q.size());
		end
		$display("Checked %0d requests across %0d count loads: %0d callers queued,",
			ledger.requests, ledger.settings, ledger.blocked);
		$display("  %0d tasks woken, %0d waits refused on a full queue, %0d failures",
			ledger.woken, ledger.refused, ledger.fails);
		if (ledger.fails == 0) begin
			$display("PASS counting_semaphore_with_wait_queue");
		end else begin
			$display("FAIL counting_semaphore_with_wait_queue");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/csem_pkg.sv
design/csem_core.sv
design/counting_semaphore_with_wait_queue.sv
design/csem_checker.sv
sim/counting_semaphore_with_wait_queue_test.sv
